### sv/fwl_pkg.sv
// Shared types and constants of the per-client fixed window limiter.
`timescale 1ns / 1ps
`default_nettype none

package fwl_pkg;

	// Width of the configuration register index.
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_REQ_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN   = 1'd1;

	// Reset values of the configuration registers.
	localparam logic [15:0] REQ_LIMIT_RST = 16'd100;
	localparam logic [15:0] WIN_LEN_RST   = 16'd60;

	// Count given to a fresh window and the saturation ceiling.
	localparam logic [15:0] COUNT_ONE = 16'd1;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// One request word as it travels from the front queue to the back end.
	typedef struct packed {
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [31:0] now;
	} req_t;

	// Per-client window state held in the back end memory.
	typedef struct packed {
		logic [31:0] win_start;
		logic [15:0] count;
	} entry_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ENCODE,
		ST_UPDATE
	} back_state_t;

endpackage

`default_nettype wire

### sv/fwl_front.sv
// Front end: accepts request words and holds them in a two-word queue.
`timescale 1ns / 1ps
`default_nettype none

module fwl_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire fwl_pkg::req_t in_req,
	output logic               head_valid,
	output fwl_pkg::req_t      head,
	input  wire logic          pop
);

	localparam int QDEPTH = 2;
	localparam int PTR_W  = 1;
	localparam int CNT_W  = 2;

	fwl_pkg::req_t      slot_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               push;
	logic               take;

	// Handshake on both sides of the queue.
	assign busy       = (cnt_q == CNT_W'(QDEPTH));
	assign push       = start && !busy;
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign take       = pop && head_valid;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (take && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Queue storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_req;
		end
	end

endmodule

`default_nettype wire

### sv/fwl_back.sv
// Back end: client table lookup, window update and result registers.
`timescale 1ns / 1ps
`default_nettype none

module fwl_back #(
	parameter int ENTRIES = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire fwl_pkg::req_t head,
	output logic               pop,
	input  wire logic [15:0]   req_limit,
	input  wire logic [15:0]   win_len,
	output logic               result_valid,
	output logic               allow,
	output logic [15:0]        request_count,
	output logic               untracked
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// Lowest set bit of a match or free vector.
	function automatic logic [IDX_W-1:0] low_index(input logic [ENTRIES-1:0] vec);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

	fwl_pkg::back_state_t state_q;
	fwl_pkg::back_state_t state_d;

	// Client table: valid bits and keys in flip-flops for the parallel compare.
	logic [ENTRIES-1:0] valid_q;
	logic [63:0]        key_hi_q [ENTRIES];
	logic [63:0]        key_lo_q [ENTRIES];

	// Window state memory.
	fwl_pkg::entry_t    mem [ENTRIES];

	fwl_pkg::req_t      req_s1;
	logic [ENTRIES-1:0] hit_vec_s1;
	logic [ENTRIES-1:0] free_vec_s1;
	logic [ENTRIES-1:0] hit_vec_d;

	fwl_pkg::req_t      req_s2;
	logic               hit_s2;
	logic               free_s2;
	logic [IDX_W-1:0]   hit_idx_s2;
	logic [IDX_W-1:0]   free_idx_s2;
	fwl_pkg::entry_t    rd_s2;

	logic               enc_en;
	logic               upd_en;
	logic [IDX_W-1:0]   hit_idx_d;

	logic [31:0]        elapsed;
	logic               restart;
	logic [15:0]        count_inc;
	logic               mem_we;
	logic               insert;
	logic [IDX_W-1:0]   wr_idx;
	fwl_pkg::entry_t    wr_data;
	logic               allow_d;
	logic [15:0]        count_d;
	logic               untracked_d;

	logic               result_valid_q;
	logic               allow_q;
	logic [15:0]        count_q;
	logic               untracked_q;

	// Sequencer: take a word, encode and read, then update.
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		enc_en  = 1'b0;
		upd_en  = 1'b0;
		unique case (state_q)
			fwl_pkg::ST_IDLE: begin
				if (head_valid) begin
					pop     = 1'b1;
					state_d = fwl_pkg::ST_ENCODE;
				end
			end
			fwl_pkg::ST_ENCODE: begin
				enc_en  = 1'b1;
				state_d = fwl_pkg::ST_UPDATE;
			end
			fwl_pkg::ST_UPDATE: begin
				upd_en  = 1'b1;
				state_d = fwl_pkg::ST_IDLE;
			end
			default: begin
				state_d = fwl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fwl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Compare the queue head against every stored key at once.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec_d[i] = valid_q[i] && (key_hi_q[i] == head.addr_hi)
				&& (key_lo_q[i] == head.addr_lo);
		end
	end

	// First stage: register the word with its match and free vectors.
	always_ff @(posedge clk) begin
		if (pop) begin
			req_s1      <= head;
			hit_vec_s1  <= hit_vec_d;
			free_vec_s1 <= ~valid_q;
		end
	end

	assign hit_idx_d = low_index(hit_vec_s1);

	// Second stage: encode the vectors and read the window state.
	always_ff @(posedge clk) begin
		if (enc_en) begin
			req_s2      <= req_s1;
			hit_s2      <= |hit_vec_s1;
			free_s2     <= |free_vec_s1;
			hit_idx_s2  <= hit_idx_d;
			free_idx_s2 <= low_index(free_vec_s1);
		end
	end

	// Window decision for the current word.
	always_comb begin
		elapsed     = req_s2.now - rd_s2.win_start;
		restart     = (elapsed >= {16'd0, win_len});
		count_inc   = (rd_s2.count == fwl_pkg::COUNT_MAX) ? rd_s2.count
			: rd_s2.count + 16'd1;
		mem_we      = 1'b0;
		insert      = 1'b0;
		wr_idx      = hit_idx_s2;
		wr_data     = '{win_start: req_s2.now, count: fwl_pkg::COUNT_ONE};
		allow_d     = 1'b1;
		count_d     = fwl_pkg::COUNT_ONE;
		untracked_d = 1'b0;
		if (hit_s2) begin
			mem_we = upd_en;
			if (!restart) begin
				wr_data = '{win_start: rd_s2.win_start, count: count_inc};
				count_d = count_inc;
				allow_d = (count_inc <= req_limit);
			end
		end else if (free_s2) begin
			mem_we = upd_en;
			insert = upd_en;
			wr_idx = free_idx_s2;
		end else begin
			count_d     = '0;
			untracked_d = 1'b1;
		end
	end

	// Window state memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx] <= wr_data;
		end
		if (enc_en) begin
			rd_s2 <= mem[hit_idx_d];
		end
	end

	// Keys of newly inserted clients.
	always_ff @(posedge clk) begin
		if (insert) begin
			key_hi_q[wr_idx] <= req_s2.addr_hi;
			key_lo_q[wr_idx] <= req_s2.addr_lo;
		end
	end

	// Valid bits and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (insert) begin
				valid_q[wr_idx] <= 1'b1;
			end
			result_valid_q <= upd_en;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (upd_en) begin
			allow_q     <= allow_d;
			count_q     <= count_d;
			untracked_q <= untracked_d;
		end
	end

	assign result_valid  = result_valid_q;
	assign allow         = allow_q;
	assign request_count = count_q;
	assign untracked     = untracked_q;

endmodule

`default_nettype wire

### sv/per_client_fixed_window_limiter_core.sv
// Top level of the per-client fixed window limiter.
`timescale 1ns / 1ps
`default_nettype none

// A request word is taken when start is high and busy is low; a two-word
// queue sits in front of the table logic, so start may be pulsed while an
// earlier request is still being worked on. Each request passes through the
// back end in order (key compare, match encode with window state read, then
// update), and the back end takes no new request before it is through with
// the last one. Its result appears on allow, request_count and untracked for
// exactly one cycle with result_valid high. The receiver cannot stall
// results. The client table needs no clearing pass after reset.
// Configuration writes are always accepted and must only be made while no
// request is in flight.
module per_client_fixed_window_limiter_core #(
	parameter int ENTRIES = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [63:0]                    client_addr_hi,
	input  wire logic [63:0]                    client_addr_lo,
	input  wire logic [31:0]                    now_seconds,
	output logic                                result_valid,
	output logic                                allow,
	output logic [15:0]                         request_count,
	output logic                                untracked,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [fwl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [15:0]                    cfg_data
);

	fwl_pkg::req_t in_req;
	fwl_pkg::req_t head;
	logic          head_valid;
	logic          pop;
	logic [15:0]   req_limit_q;
	logic [15:0]   win_len_q;

	assign in_req    = '{addr_hi: client_addr_hi, addr_lo: client_addr_lo, now: now_seconds};
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_limit_q <= fwl_pkg::REQ_LIMIT_RST;
			win_len_q   <= fwl_pkg::WIN_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fwl_pkg::REG_REQ_LIMIT: req_limit_q <= cfg_data;
				fwl_pkg::REG_WIN_LEN:   win_len_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Request queue.
	fwl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.in_req     (in_req),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// Table lookup and window update.
	fwl_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.req_limit      (req_limit_q),
		.win_len        (win_len_q),
		.result_valid   (result_valid),
		.allow          (allow),
		.request_count  (request_count),
		.untracked      (untracked)
	);

	// The back end never delivers results in adjacent cycles.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("results delivered in adjacent cycles");

	// An untracked client is always passed with a zero count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && untracked) |-> (allow && request_count == 16'd0))
		else $error("untracked result with wrong allow or count");

	// A rejection only happens when the count is above the limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !allow) |-> (request_count > req_limit_q && !untracked))
		else $error("rejection without the count above the limit");

	// A word is only taken from the queue when the queue holds one.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

endmodule

`default_nettype wire
